### rtl/core/rphd_pkg.sv
package rphd_pkg;

  localparam int PACKET_BYTES = 21;
  localparam int HOP_SLOTS    = 16;
  localparam int STICKS       = 8;
  localparam int WORD_BITS    = 16;
  localparam int OFFSET_LIMIT = 9;

  localparam logic [15:0] STICK_MIN = 16'd1000;
  localparam logic [15:0] STICK_MAX = 16'd2000;
  localparam logic signed [16:0] STICK_MID = 17'sd1500;

  localparam logic KIND_TUNE  = 1'b0;
  localparam logic KIND_STICK = 1'b1;

  typedef enum logic [1:0] {
    CMD_HOP     = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_BYTE    = 2'd2,
    CMD_SPARE   = 2'd3
  } command_t;

  typedef struct packed {
    logic                          kind;
    logic [7:0]                    channel;
    logic [STICKS*WORD_BITS-1:0]   words;
  } entry_t;

  localparam logic [7:0] HOP_TABLE [HOP_SLOTS][HOP_SLOTS] = '{
    '{8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0},
    '{8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a},
    '{8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82},
    '{8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a},
    '{8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96},
    '{8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28},
    '{8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64},
    '{8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50},
    '{8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64},
    '{8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50},
    '{8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
    '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46},
    '{8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82},
    '{8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46},
    '{8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
    '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46}
  };

  // Throttle and aux2..aux4 use 130, aux1 uses 131, the rest 64.
  function automatic logic [7:0] stick_scale(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd2, 3'd5, 3'd6, 3'd7: s = 8'd130;
      3'd4:                   s = 8'd131;
      default:                s = 8'd64;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/rphd_front.sv
module rphd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [31:0]          cfg_transmitter_id,
  input  logic                 in_accept,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_frame_error,
  input  logic                 in_last_byte,
  output logic                 push,
  output rphd_pkg::entry_t     push_entry
);

  localparam logic [4:0] LAST_SLOT  = 5'(rphd_pkg::PACKET_BYTES - 1);
  localparam logic [4:0] COUNT_SAT  = 5'd31;
  localparam logic [3:0] OFF_LIMIT  = 4'(rphd_pkg::OFFSET_LIMIT);

  logic [31:0] id_r;
  logic [3:0]  column_r, column_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [7:0]  store_r [rphd_pkg::PACKET_BYTES];

  logic [3:0]  offset;
  logic [7:0]  channel;
  logic [31:0] frame_id;
  logic        frame_ok;
  logic [rphd_pkg::STICKS*rphd_pkg::WORD_BITS-1:0] words;

  assign offset   = (id_r[7:4] > OFF_LIMIT) ? OFF_LIMIT : id_r[7:4];
  assign channel  = rphd_pkg::HOP_TABLE[id_r[3:0]][column_r] - 8'd1 - {4'd0, offset};
  assign frame_id = {store_r[4], store_r[3], store_r[2], store_r[1]};

  // The final byte of a full frame is still on the input, so it is taken from there.
  assign frame_ok = (in_command == rphd_pkg::CMD_BYTE) && in_last_byte && !in_frame_error &&
                    (count_r == LAST_SLOT) && (frame_id == id_r);

  always_comb begin
    for (int k = 0; k < rphd_pkg::STICKS - 1; k++) begin
      words[k*16 +: 16] = {store_r[6 + 2*k], store_r[5 + 2*k]};
    end
    words[(rphd_pkg::STICKS-1)*16 +: 16] = {in_data_byte, store_r[19]};
  end

  always_comb begin
    column_nxt = column_r;
    count_nxt  = count_r;
    case (in_command)
      rphd_pkg::CMD_HOP, rphd_pkg::CMD_TIMEOUT: begin
        column_nxt = column_r + 4'd1;
        count_nxt  = '0;
      end
      rphd_pkg::CMD_BYTE: begin
        if (in_last_byte) begin
          count_nxt = '0;
        end else if (count_r != COUNT_SAT) begin
          count_nxt = count_r + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push               = in_accept && ((in_command == rphd_pkg::CMD_HOP) || frame_ok);
    push_entry.kind    = (in_command == rphd_pkg::CMD_HOP) ? rphd_pkg::KIND_TUNE
                                                           : rphd_pkg::KIND_STICK;
    push_entry.channel = channel;
    push_entry.words   = words;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r     <= 32'd5961;
      column_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_write_en) begin
        id_r <= cfg_transmitter_id;
      end
      if (in_accept) begin
        column_r <= column_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_command == rphd_pkg::CMD_BYTE)) begin
      for (int i = 0; i < rphd_pkg::PACKET_BYTES; i++) begin
        if (count_r == 5'(i)) begin
          store_r[i] <= in_data_byte;
        end
      end
    end
  end

endmodule

### rtl/core/rphd_queue.sv
module rphd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rphd_pkg::entry_t     push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output rphd_pkg::entry_t     head_entry
);

  rphd_pkg::entry_t entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_entry = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/core/rphd_back.sv
module rphd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  rphd_pkg::entry_t     head_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_tune_channel,
  output logic [2:0]           out_stick_index,
  output logic signed [16:0]   out_stick_value,
  output logic                 out_last
);

  localparam int WORDS_W = rphd_pkg::STICKS * rphd_pkg::WORD_BITS;

  logic               valid_r, valid_nxt;
  logic               busy_r, busy_nxt;
  logic               kind_r, kind_nxt;
  logic [7:0]         chan_r, chan_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic signed [16:0] val_r;
  logic               last_r, last_nxt;
  logic [WORDS_W-1:0] words_r, words_nxt;

  logic               advance;
  logic [15:0]        word, wclamp;
  logic signed [16:0] diff, prod;

  assign advance = !valid_r || !out_stall;
  assign pop     = advance && !busy_r && head_valid;

  always_comb begin
    word = busy_r ? words_r[15:0] : head_entry.words[15:0];
    if (word < rphd_pkg::STICK_MIN) begin
      wclamp = rphd_pkg::STICK_MIN;
    end else if (word > rphd_pkg::STICK_MAX) begin
      wclamp = rphd_pkg::STICK_MAX;
    end else begin
      wclamp = word;
    end
    diff = $signed({1'b0, wclamp}) - rphd_pkg::STICK_MID;
    prod = diff * $signed({9'd0, rphd_pkg::stick_scale(idx_nxt)});
  end

  always_comb begin
    valid_nxt = valid_r;
    busy_nxt  = busy_r;
    kind_nxt  = kind_r;
    chan_nxt  = chan_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    words_nxt = words_r;
    if (advance) begin
      if (busy_r) begin
        // Remaining sticks of a frame shift out one word per result.
        valid_nxt = 1'b1;
        idx_nxt   = idx_r + 3'd1;
        busy_nxt  = (idx_r != 3'd6);
        last_nxt  = (idx_r == 3'd6);
        words_nxt = words_r >> rphd_pkg::WORD_BITS;
      end else if (head_valid) begin
        valid_nxt = 1'b1;
        kind_nxt  = head_entry.kind;
        idx_nxt   = '0;
        words_nxt = head_entry.words >> rphd_pkg::WORD_BITS;
        if (head_entry.kind == rphd_pkg::KIND_TUNE) begin
          chan_nxt = head_entry.channel;
          busy_nxt = 1'b0;
          last_nxt = 1'b1;
        end else begin
          chan_nxt = '0;
          busy_nxt = 1'b1;
          last_nxt = 1'b0;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    chan_r  <= chan_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    words_r <= words_nxt;
    if (advance) begin
      val_r <= (busy_r || (head_entry.kind == rphd_pkg::KIND_STICK)) ? prod : '0;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_tune_channel = chan_r;
  assign out_stick_index  = idx_r;
  assign out_stick_value  = val_r;
  assign out_last         = last_r;

  a_busy_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (valid_r && (kind_r == rphd_pkg::KIND_STICK) && (idx_r != 3'd7)))
    else $error("stick burst in progress without a pending stick result");

  a_tune_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == rphd_pkg::KIND_TUNE)) |-> last_r)
    else $error("tune result not marked last");

  a_stick_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == rphd_pkg::KIND_STICK)) |-> (last_r == (idx_r == 3'd7)))
    else $error("last flag does not match final stick");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("queue popped during stick burst");

endmodule

### rtl/core/rc_packet_hop_decoder.sv
// Radio control receiver core: hop commands return the channel to tune to,
// packet bytes are gathered into a frame, and a full frame that carries the
// bound transmitter id and no error yields eight centered, scaled stick values
// (yaw, roll, throttle, pitch, aux1..aux4), the eighth marked last. One item
// is accepted per cycle while in_stall is low; in_stall rises only while the
// two-entry queue between the byte collector and the result stage is full.
// A tune is a single result from that stage, so a run of hops sustains
// one item per cycle while out_stall is low; an accepted frame holds it for
// eight results, one stick per cycle while out_stall is low, with no new item
// taken meanwhile. Write cfg_transmitter_id only while no results are pending.
module rc_packet_hop_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [31:0]         cfg_transmitter_id,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_error,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic [7:0]          out_tune_channel,
  output logic [2:0]          out_stick_index,
  output logic signed [16:0]  out_stick_value,
  output logic                out_last
);

  logic             push, full, pop, head_valid, in_accept;
  rphd_pkg::entry_t push_entry, head_entry;

  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  rphd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_transmitter_id (cfg_transmitter_id),
    .in_accept          (in_accept),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_frame_error     (in_frame_error),
    .in_last_byte       (in_last_byte),
    .push               (push),
    .push_entry         (push_entry)
  );

  rphd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rphd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_tune_channel (out_tune_channel),
    .out_stick_index  (out_stick_index),
    .out_stick_value  (out_stick_value),
    .out_last         (out_last)
  );

endmodule
